// ===== rtl/tdfsm_pkg.sv =====
// Shared types and constants of the table-driven state machine engine.
`default_nettype none

package tdfsm_pkg;

    localparam int NUM_TRANSITIONS = 16;
    localparam int NUM_STATES      = 8;
    localparam int TIMEOUT_BITS    = 16;

    localparam int ENTRY_BITS   = 16;
    localparam int TABLE_WORDS  = 4;
    localparam int ELAPSED_BITS = 17;

    // entry layout
    localparam int E_VALID     = 0;
    localparam int E_EVENT_LSB = 1;
    localparam int E_SRC_LSB   = 6;
    localparam int E_TGT_LSB   = 10;
    localparam int E_GUARDED   = 13;

    localparam logic [3:0] ANY_SOURCE = 4'd8;
    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;
    localparam logic [15:0] TIMEOUT_MASK = 16'((32'd1 << TIMEOUT_BITS) - 32'd1);

    typedef enum logic [1:0] {
        ACT_EVENT = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_START = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        CFG_TABLE_0  = 3'd0,
        CFG_TABLE_1  = 3'd1,
        CFG_TABLE_2  = 3'd2,
        CFG_TABLE_3  = 3'd3,
        CFG_TMO_LOW  = 3'd4,
        CFG_TMO_HIGH = 3'd5,
        CFG_INIT     = 3'd6
    } cfg_index_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EXEC = 1'b1
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/table_driven_fsm_engine_top.sv =====
// Top level of the table-driven state machine engine with per-state timeouts.
`default_nettype none

// Programmable state machine: sixteen transition entries and eight per-state
// timeouts are loaded through the cfg_* write port, then items arrive on the
// s_* channel (start, event or tick) and each one yields exactly one result
// transfer on the m_* channel reporting the state and what happened. Each item
// is first captured into the input registers; then the priority match over the
// transition table and the state/elapsed-count update load the output register.
// The controller handles one item at a time and takes no new item before the
// last one is executed; the next item is taken while the previous result is
// still being transferred. Configuration writes are registered and should only
// be issued while the engine is idle. Inputs other than start are ignored until
// the first start.

module table_driven_fsm_engine_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    // item channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [3:0]  s_event_code,
    input  wire logic [15:0] s_guard_ok,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_state_now,
    output logic             m_running,
    output logic             m_moved,
    output logic [3:0]       m_taken_entry,
    output logic [2:0]       m_left_state,
    output logic             m_guard_blocked,
    output logic             m_timeout_fired,
    output logic             m_no_match
);
    import tdfsm_pkg::*;

    dp_cmd_t cmd;

    // sequencing and handshakes
    tdfsm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // config store, table match, state and result registers
    tdfsm_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_action        (s_action),
        .s_event_code    (s_event_code),
        .s_guard_ok      (s_guard_ok),
        .m_state_now     (m_state_now),
        .m_running       (m_running),
        .m_moved         (m_moved),
        .m_taken_entry   (m_taken_entry),
        .m_left_state    (m_left_state),
        .m_guard_blocked (m_guard_blocked),
        .m_timeout_fired (m_timeout_fired),
        .m_no_match      (m_no_match)
    );

`ifndef SYNTH
    // never take an item while a result would be overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("item taken while result register busy");

    // one item in flight: no acceptance in the execute cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted during execution");

    // every accepted item produces a result after its execute state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ##1 m_valid)
        else $error("result missing after accepted item");

    // a stopped machine never moves, times out or reports a missing match
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_running) |-> (!m_moved && !m_timeout_fired && !m_no_match))
        else $error("activity reported while not running");

    // a transition excludes both a guard block and a missing match
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_moved && (m_guard_blocked || m_no_match)))
        else $error("conflicting result flags");
`endif

endmodule

`default_nettype wire

// ===== rtl/tdfsm_ctrl.sv =====
// Controller of the state machine engine: handshakes and sequencing.
`default_nettype none

module tdfsm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tdfsm_pkg::dp_cmd_t     cmd
);
    import tdfsm_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        accept;

    // output register must be empty, or emptied this cycle, before taking an item
    assign accept = (state_reg == CS_IDLE) && (!m_valid_reg || m_ready) && s_valid;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (accept) begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC: state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_ready     = !m_valid_reg || m_ready;
                cmd.load_in = accept;
            end
            CS_EXEC: cmd.exec = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/tdfsm_dp.sv =====
// Datapath of the state machine engine: config store, match and state update.
`default_nettype none

module tdfsm_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire tdfsm_pkg::dp_cmd_t  cmd,
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [63:0]         cfg_data,
    input  wire logic [1:0]          s_action,
    input  wire logic [3:0]          s_event_code,
    input  wire logic [15:0]         s_guard_ok,
    output logic [2:0]               m_state_now,
    output logic                     m_running,
    output logic                     m_moved,
    output logic [3:0]               m_taken_entry,
    output logic [2:0]               m_left_state,
    output logic                     m_guard_blocked,
    output logic                     m_timeout_fired,
    output logic                     m_no_match
);
    import tdfsm_pkg::*;

    // configuration
    logic [63:0] table_reg [TABLE_WORDS];
    logic [63:0] tmo_low_reg, tmo_high_reg;
    logic [2:0]  init_state_reg;

    // machine state
    logic                    started_reg, started_next;
    logic [2:0]              state_reg, state_next;
    logic [ELAPSED_BITS-1:0] elapsed_reg, elapsed_next;

    // captured item
    action_t     action_reg;
    logic [3:0]  event_reg;
    logic [15:0] guard_reg;

    // result register
    logic        moved_reg, moved_next;
    logic [3:0]  taken_reg, taken_next;
    logic [2:0]  left_reg, left_next;
    logic        blocked_reg, blocked_next;
    logic        fired_reg, fired_next;
    logic        nomatch_reg, nomatch_next;

    logic [ENTRY_BITS*NUM_TRANSITIONS-1:0] entries;
    logic [NUM_TRANSITIONS-1:0]        hit;
    logic [4:0]                        ev_code;
    logic                              found;
    logic [3:0]                        hit_idx;
    logic [ENTRY_BITS-1:0]             hit_entry;
    logic [2:0]                        hit_tgt;
    logic                              hit_blocked;
    logic [63:0]                       tmo_word;
    logic [15:0]                       limit;
    logic [ELAPSED_BITS-1:0]           elapsed_inc;
    logic                              tmo_hit;

    assign entries = {table_reg[3], table_reg[2], table_reg[1], table_reg[0]};

    // tick raises event 16 + state
    assign ev_code = (action_reg == ACT_TICK) ? {2'b10, state_reg} : {1'b0, event_reg};

    always_comb begin
        logic [ENTRY_BITS-1:0] e;
        logic [3:0]            src;
        hit = '0;
        for (int i = 0; i < NUM_TRANSITIONS; i++) begin
            e   = entries[i*ENTRY_BITS +: ENTRY_BITS];
            src = e[E_SRC_LSB +: 4];
            hit[i] = e[E_VALID] && (e[E_EVENT_LSB +: 5] == ev_code) &&
                     ((src == ANY_SOURCE) ||
                      ((src < 4'(NUM_STATES)) && (src == {1'b0, state_reg})));
        end
    end

    // first hit wins
    always_comb begin
        found   = 1'b0;
        hit_idx = '0;
        for (int i = NUM_TRANSITIONS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found   = 1'b1;
                hit_idx = 4'(i);
            end
        end
    end

    assign hit_entry   = entries[{hit_idx, 4'b0} +: ENTRY_BITS];
    assign hit_blocked = hit_entry[E_GUARDED] && !guard_reg[hit_idx];
    assign hit_tgt     = ({1'b0, hit_entry[E_TGT_LSB +: 3]} >= 4'(NUM_STATES)) ?
                         3'(NUM_STATES - 1) : hit_entry[E_TGT_LSB +: 3];

    assign tmo_word    = state_reg[2] ? tmo_high_reg : tmo_low_reg;
    assign limit       = tmo_word[{state_reg[1:0], 4'b0} +: 16] & TIMEOUT_MASK;
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                       : elapsed_reg + 1'b1;
    assign tmo_hit     = (limit != '0) && (elapsed_inc > {1'b0, limit});

    always_comb begin
        logic raise;
        raise        = 1'b0;
        started_next = started_reg;
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        moved_next   = 1'b0;
        taken_next   = '0;
        left_next    = '0;
        blocked_next = 1'b0;
        fired_next   = 1'b0;
        nomatch_next = 1'b0;
        unique case (action_reg)
            ACT_START: begin
                started_next = 1'b1;
                elapsed_next = '0;
                state_next   = ({1'b0, init_state_reg} < 4'(NUM_STATES)) ?
                               init_state_reg : '0;
            end
            ACT_EVENT: raise = started_reg;
            ACT_TICK: begin
                if (started_reg) begin
                    elapsed_next = elapsed_inc;
                    if (tmo_hit) begin
                        elapsed_next = '0;
                        fired_next   = 1'b1;
                        raise        = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (raise) begin
            if (found) begin
                taken_next = hit_idx;
                if (hit_blocked) begin
                    blocked_next = 1'b1;
                end else begin
                    moved_next   = 1'b1;
                    left_next    = state_reg;
                    state_next   = hit_tgt;
                    elapsed_next = '0;
                end
            end else begin
                nomatch_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < TABLE_WORDS; w++) begin
                table_reg[w] <= '0;
            end
            tmo_low_reg    <= '0;
            tmo_high_reg   <= '0;
            init_state_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TABLE_0, CFG_TABLE_1, CFG_TABLE_2, CFG_TABLE_3:
                    table_reg[cfg_index[1:0]] <= cfg_data;
                CFG_TMO_LOW:  tmo_low_reg    <= cfg_data;
                CFG_TMO_HIGH: tmo_high_reg   <= cfg_data;
                CFG_INIT:     init_state_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            state_reg   <= '0;
            elapsed_reg <= '0;
        end else if (cmd.exec) begin
            started_reg <= started_next;
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg <= action_t'(s_action);
            event_reg  <= s_event_code;
            guard_reg  <= s_guard_ok;
        end
        if (cmd.exec) begin
            moved_reg   <= moved_next;
            taken_reg   <= taken_next;
            left_reg    <= left_next;
            blocked_reg <= blocked_next;
            fired_reg   <= fired_next;
            nomatch_reg <= nomatch_next;
        end
    end

    assign m_state_now     = state_reg;
    assign m_running       = started_reg;
    assign m_moved         = moved_reg;
    assign m_taken_entry   = taken_reg;
    assign m_left_state    = left_reg;
    assign m_guard_blocked = blocked_reg;
    assign m_timeout_fired = fired_reg;
    assign m_no_match      = nomatch_reg;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the table-driven state machine engine.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdfsm_pkg::*;

    // action code with no meaning to the engine, still legal on the port
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    // results between the receiver's long hold-offs, and how long each hold-off lasts
    localparam int HOLD_EVERY  = 600;
    localparam int HOLD_CYCLES = 120;
    // ticks run with timeouts off, then a timeout well below that count
    localparam int          LONG_TICKS   = 200;
    localparam logic [15:0] LATE_TIMEOUT = 16'd150;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  event_code;
        logic [15:0] guard_ok;
    } fsm_item_t;

    typedef struct packed {
        logic [2:0] state_now;
        logic       running;
        logic       moved;
        logic [3:0] taken_entry;
        logic [2:0] left_state;
        logic       guard_blocked;
        logic       timeout_fired;
        logic       no_match;
    } fsm_status_t;

    // ---------------------------------------------------------------
    // DUT connections: every input has a known value from time zero
    // ---------------------------------------------------------------
    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_wr_en    = 1'b0;
    logic [2:0]  cfg_index    = CFG_TABLE_0;
    logic [63:0] cfg_data     = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action     = ACT_EVENT;
    logic [3:0]  s_event_code = '0;
    logic [15:0] s_guard_ok   = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [2:0]  m_state_now;
    logic        m_running;
    logic        m_moved;
    logic [3:0]  m_taken_entry;
    logic [2:0]  m_left_state;
    logic        m_guard_blocked;
    logic        m_timeout_fired;
    logic        m_no_match;

    table_driven_fsm_engine_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_event_code    (s_event_code),
        .s_guard_ok      (s_guard_ok),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_state_now     (m_state_now),
        .m_running       (m_running),
        .m_moved         (m_moved),
        .m_taken_entry   (m_taken_entry),
        .m_left_state    (m_left_state),
        .m_guard_blocked (m_guard_blocked),
        .m_timeout_fired (m_timeout_fired),
        .m_no_match      (m_no_match)
    );

    always #4 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Shadow of the engine: configuration and machine state
    // ---------------------------------------------------------------
    logic [63:0]             mdl_table [4];
    logic [63:0]             mdl_tmo   [2];   // [0] states 0-3, [1] states 4-7
    logic [2:0]              mdl_init;
    logic                    mdl_started;
    logic [2:0]              mdl_state;
    logic [ELAPSED_BITS-1:0] mdl_elapsed;

    // items waiting to be offered, and status words still owed by the engine
    fsm_item_t   pending_items[$];
    fsm_status_t predicted_status[$];

    // run bookkeeping
    int  fail_count = 0;
    int  rx_count   = 0;
    bit  full_rate  = 1'b0;   // both sides run flat out, no gaps or holds

    // driver and monitor private counters
    int        tx_gap    = 0;
    bit        tx_calm   = 1'b0;
    int        rx_stall  = 0;
    int        rx_hold   = 0;
    bit        rx_calm   = 1'b0;
    fsm_status_t got_status;
    fsm_status_t want_status;

    // Priority match over the transition table. First valid entry with a
    // matching event and source wins; a false guard drops the event there.
    function automatic void fire_event(input logic [4:0] ev, input logic [15:0] guards,
                                       inout fsm_status_t st);
        logic [15:0] ent;
        logic [3:0]  src;
        logic [2:0]  tgt;
        bit          found;
        found = 1'b0;
        for (int i = 0; i < NUM_TRANSITIONS; i++) begin
            if (!found) begin
                ent = mdl_table[i / 4][(i % 4) * 16 +: 16];
                src = ent[E_SRC_LSB +: 4];
                tgt = ent[E_TGT_LSB +: 3];
                if (ent[E_VALID] && ent[E_EVENT_LSB +: 5] == ev &&
                    (src == ANY_SOURCE || (src < NUM_STATES && src[2:0] == mdl_state))) begin
                    found          = 1'b1;
                    st.taken_entry = 4'(i);
                    if (ent[E_GUARDED] && !guards[i]) begin
                        st.guard_blocked = 1'b1;
                    end else begin
                        if (tgt >= NUM_STATES) tgt = 3'(NUM_STATES - 1);
                        st.moved      = 1'b1;
                        st.left_state = mdl_state;
                        mdl_state     = tgt;
                        mdl_elapsed   = '0;
                    end
                end
            end
        end
        if (!found) st.no_match = 1'b1;
    endfunction

    // Advance the shadow machine by one item and return the status it owes.
    function automatic fsm_status_t advance_machine(input fsm_item_t it);
        fsm_status_t st;
        logic [15:0] lim;
        st = '0;
        case (it.action)
            ACT_START: begin
                mdl_state   = (mdl_init < NUM_STATES) ? mdl_init : 3'd0;
                mdl_elapsed = '0;
                mdl_started = 1'b1;
            end
            ACT_EVENT: begin
                if (mdl_started) fire_event({1'b0, it.event_code}, it.guard_ok, st);
            end
            ACT_TICK: begin
                if (mdl_started) begin
                    lim = mdl_tmo[mdl_state[2]][mdl_state[1:0] * 16 +: 16] & TIMEOUT_MASK;
                    if (mdl_elapsed != ELAPSED_MAX) mdl_elapsed = mdl_elapsed + 1'b1;
                    if (lim != 0 && mdl_elapsed > {1'b0, lim}) begin
                        mdl_elapsed      = '0;
                        st.timeout_fired = 1'b1;
                        // timeout event code is 16 + current state
                        fire_event({2'b10, mdl_state}, it.guard_ok, st);
                    end
                end
            end
            default: ;
        endcase
        st.state_now = mdl_state;
        st.running   = mdl_started;
        return st;
    endfunction

    function automatic string show_status(input fsm_status_t st);
        return $sformatf("state=%0d run=%0b moved=%0b entry=%0d left=%0d blk=%0b tmo=%0b nm=%0b",
                         st.state_now, st.running, st.moved, st.taken_entry,
                         st.left_state, st.guard_blocked, st.timeout_fired, st.no_match);
    endfunction

    function automatic logic [15:0] make_entry(input bit vld, input int ev, input int src,
                                               input int tgt, input bit guarded);
        logic [15:0] e;
        e                  = '0;
        e[E_VALID]         = vld;
        e[E_EVENT_LSB +: 5] = 5'(ev);
        e[E_SRC_LSB +: 4]  = 4'(src);
        e[E_TGT_LSB +: 3]  = 3'(tgt);
        e[E_GUARDED]       = guarded;
        return e;
    endfunction

    // Random entry biased towards events and sources that actually occur,
    // with the spare top bits and out-of-range sources left to chance.
    function automatic logic [15:0] rand_entry();
        logic [15:0] e;
        e          = 16'($urandom);
        e[E_VALID] = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 3) != 0)
            e[E_EVENT_LSB +: 5] = ($urandom_range(0, 2) == 0) ? 5'(16 + $urandom_range(0, 7))
                                                               : 5'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0)
            e[E_SRC_LSB +: 4] = ($urandom_range(0, 2) == 0) ? ANY_SOURCE
                                                             : 4'($urandom_range(0, 7));
        return e;
    endfunction

    // Timeout lanes: mostly short so that they fire, some off, a few long.
    function automatic logic [63:0] rand_timeouts();
        logic [63:0] w;
        int          pick;
        for (int s = 0; s < 4; s++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)      w[s * 16 +: 16] = '0;
            else if (pick < 85) w[s * 16 +: 16] = 16'($urandom_range(1, 6));
            else                w[s * 16 +: 16] = 16'($urandom);
        end
        return w;
    endfunction

    function automatic fsm_item_t rand_item();
        fsm_item_t it;
        int        pick;
        pick          = $urandom_range(0, 99);
        it.event_code = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        it.guard_ok   = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'hFFFF;
        if (pick < 3)       it.action = ACT_START;
        else if (pick < 5)  it.action = ACT_UNKNOWN;
        else if (pick < 52) it.action = ACT_TICK;
        else                it.action = ACT_EVENT;
        return it;
    endfunction

    task automatic queue_item(input logic [1:0] act, input int ev, input logic [15:0] guards);
        fsm_item_t it;
        it.action     = act;
        it.event_code = 4'(ev);
        it.guard_ok   = guards;
        pending_items.push_back(it);
    endtask

    // One register write; the shadow copy is updated as the write is driven onto the port.
    task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_TABLE_0, CFG_TABLE_1, CFG_TABLE_2, CFG_TABLE_3: mdl_table[idx[1:0]] = val;
            CFG_TMO_LOW:  mdl_tmo[0] = val;
            CFG_TMO_HIGH: mdl_tmo[1] = val;
            CFG_INIT:     mdl_init   = val[2:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_config(input logic [3:0][63:0] tbl, input logic [63:0] tmo_lo,
                               input logic [63:0] tmo_hi, input logic [2:0] init);
        write_reg(CFG_TABLE_0, tbl[0]);
        write_reg(CFG_TABLE_1, tbl[1]);
        write_reg(CFG_TABLE_2, tbl[2]);
        write_reg(CFG_TABLE_3, tbl[3]);
        write_reg(CFG_TMO_LOW, tmo_lo);
        write_reg(CFG_TMO_HIGH, tmo_hi);
        write_reg(CFG_INIT, 64'(init));
    endtask

    // Sender stops until every item has gone in and every status is back;
    // sampled on the falling edge so the clocked processes have settled.
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || predicted_status.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Driver: offers queued items with a random gap before each one.
    // Valid stays up with a steady payload until the transfer happens.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  = 0;
        end else begin
            if (s_valid && s_ready)
                predicted_status.push_back(advance_machine({s_action, s_event_code, s_guard_ok}));
            if (s_valid && !s_ready) begin
                // still waiting for the transfer, hold everything
            end else if (tx_gap > 0) begin
                tx_gap  = tx_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                fsm_item_t nxt;
                nxt = pending_items.pop_front();
                s_action     <= nxt.action;
                s_event_code <= nxt.event_code;
                s_guard_ok   <= nxt.guard_ok;
                s_valid      <= 1'b1;
                // gap ahead of the following item; calm spells run back to back
                if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
                tx_gap = (full_rate || tx_calm) ? 0 : $urandom_range(0, 11);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest prediction
    // and paces m_ready with random stalls and the odd long hold-off.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_status = {m_state_now, m_running, m_moved, m_taken_entry, m_left_state,
                              m_guard_blocked, m_timeout_fired, m_no_match};
                if (predicted_status.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected result: %s", $realtime,
                                 show_status(got_status));
                end else begin
                    want_status = predicted_status.pop_front();
                    if (got_status !== want_status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("[%0t] result %0d mismatch\n  exp %s\n  got %s",
                                     $realtime, rx_count, show_status(want_status),
                                     show_status(got_status));
                    end
                end
                rx_count++;
                // long hold-off lets the engine fill up and push back on s_ready
                if (!full_rate && rx_count % HOLD_EVERY == HOLD_EVERY / 2)
                    rx_hold = HOLD_CYCLES;
                if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
                rx_stall = (full_rate || rx_calm) ? 0 : $urandom_range(0, 11);
            end
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                m_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall = rx_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus sequence
    // ---------------------------------------------------------------
    initial begin
        logic [3:0][63:0] tbl;
        logic [63:0]      tmo_lo;
        logic [63:0]      tmo_hi;
        int               n_items;

        mdl_table   = '{default: '0};
        mdl_tmo     = '{default: '0};
        mdl_init    = '0;
        mdl_started = 1'b0;
        mdl_state   = '0;
        mdl_elapsed = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Not yet started: event, tick and the unknown action change nothing
        queue_item(ACT_EVENT, 1, 16'hFFFF);
        queue_item(ACT_TICK, 0, 16'h0000);
        queue_item(ACT_UNKNOWN, 15, 16'hFFFF);
        wait_drained();

        // Directed table: wildcard source, guard drop that hides a later
        // entry, out-of-range source, timeout transitions, disabled entry,
        // self-transition and the last entry of the table.
        tbl    = '0;
        tbl[0] = {make_entry(1, 3, 12, 1, 0), make_entry(1, 2, 2, 6, 0),
                  make_entry(1, 2, 2, 5, 1),  make_entry(1, 1, ANY_SOURCE, 2, 0)};
        tbl[1] = {make_entry(1, 0, 3, 3, 0),  make_entry(0, 4, ANY_SOURCE, 1, 0),
                  make_entry(1, 16, ANY_SOURCE, 0, 1), make_entry(1, 21, 5, 0, 0)};
        tbl[3] = {make_entry(1, 15, ANY_SOURCE, 3, 0), 48'h0};
        load_config(tbl, {16'd1, 16'd0, 16'd3, 16'd2}, {16'd3, 16'd3, 16'd1, 16'd3}, 3'd0);

        queue_item(ACT_START, 0, 16'h0000);
        queue_item(ACT_EVENT, 1, 16'hFFFF);     // 0 -> 2 on wildcard entry
        queue_item(ACT_EVENT, 2, 16'hFFFD);     // guard false, later entry not tried
        queue_item(ACT_EVENT, 2, 16'hFFFF);     // 2 -> 5
        queue_item(ACT_TICK, 0, 16'hFFFF);
        queue_item(ACT_TICK, 0, 16'hFFFF);      // timeout of 5 moves to 0
        queue_item(ACT_TICK, 0, 16'h0000);
        queue_item(ACT_TICK, 0, 16'h0000);
        queue_item(ACT_TICK, 0, 16'h0000);      // timeout of 0, guarded entry blocked
        queue_item(ACT_EVENT, 3, 16'hFFFF);     // source out of range, no match
        queue_item(ACT_EVENT, 4, 16'hFFFF);     // only a disabled entry, no match
        queue_item(ACT_EVENT, 15, 16'h8000);    // last entry, to 3
        queue_item(ACT_EVENT, 0, 16'h0000);     // self-transition
        queue_item(ACT_TICK, 0, 16'hFFFF);
        queue_item(ACT_TICK, 0, 16'hFFFF);      // timeout with nothing to match
        queue_item(ACT_EVENT, 9, 16'hFFFF);
        queue_item(ACT_START, 7, 16'hFFFF);     // restart while running
        queue_item(ACT_UNKNOWN, 0, 16'h0000);
        queue_item(ACT_EVENT, 1, 16'h0000);     // unguarded entry ignores guard bits
        queue_item(ACT_TICK, 0, 16'hFFFF);
        wait_drained();

        // Random phases: all-ones and all-zero extremes first, then random tables
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    tbl = '1; tmo_lo = '1; tmo_hi = '1;
                    load_config(tbl, tmo_lo, tmo_hi, 3'd7);
                    n_items = 150;
                end
                1: begin
                    tbl = '0; tmo_lo = '0; tmo_hi = '0;
                    load_config(tbl, tmo_lo, tmo_hi, 3'd0);
                    n_items = 150;
                end
                default: begin
                    for (int i = 0; i < NUM_TRANSITIONS; i++)
                        tbl[i / 4][(i % 4) * 16 +: 16] = rand_entry();
                    load_config(tbl, rand_timeouts(), rand_timeouts(),
                                3'($urandom_range(0, 7)));
                    n_items = 300;
                end
            endcase
            queue_item(ACT_START, 0, 16'h0000);
            for (int k = 0; k < n_items; k++) pending_items.push_back(rand_item());
            wait_drained();
        end

        // Elapsed count keeps running while timeouts are off; a timeout set
        // below the count afterwards fires on the very next tick.
        full_rate = 1'b1;
        write_reg(CFG_TMO_LOW, 64'h0);
        write_reg(CFG_TMO_HIGH, 64'h0);
        queue_item(ACT_START, 0, 16'hFFFF);
        for (int k = 0; k < LONG_TICKS; k++) queue_item(ACT_TICK, 0, 16'hFFFF);
        wait_drained();
        write_reg(CFG_TMO_LOW, {4{LATE_TIMEOUT}});
        write_reg(CFG_TMO_HIGH, {4{LATE_TIMEOUT}});
        queue_item(ACT_TICK, 0, 16'hFFFF);
        queue_item(ACT_TICK, 0, 16'h0000);
        wait_drained();
        full_rate = 1'b0;

        repeat (20) @(posedge aclk);
        if (predicted_status.size() != 0) begin
            fail_count++;
            $display("%0d results never arrived", predicted_status.size());
        end
        if (fail_count == 0) begin
            $display("table_driven_fsm_engine_top verification clean");
        end else begin
            $display("table_driven_fsm_engine_top verification failed");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run with every stall drawn long
    initial begin
        #8ms;
        $display("table_driven_fsm_engine_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire
